### hw/rtl/ter_pkg.sv
// Shared types, constants and control-store contents for the tab expansion renderer.
// No dependencies; every other file of the block uses it.

package ter_pkg;

	localparam int MAX_INDENT = 16;
	localparam int IW_W       = 5;                  // indent_width register
	localparam int PH_W       = $clog2(MAX_INDENT); // column phase
	localparam int CHAR_W     = 8;
	localparam int HL_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = IW_W;
	localparam int PC_W       = 2;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_MARK  = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_SUBST = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

	localparam logic [HL_W-1:0] HL_NORM     = 2'd0;
	localparam logic [HL_W-1:0] HL_TABFILL  = 2'd1;
	localparam logic [HL_W-1:0] HL_SUBST    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INDENT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABS_MODE = 1'd1;

	localparam logic [IW_W-1:0] INDENT_RST = 5'd4;
	localparam logic [IW_W-1:0] INDENT_MAX = IW_W'(MAX_INDENT);

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_FETCH  = 2'd0;
	localparam pc_t STEP_REDUCE = 2'd1;
	localparam pc_t STEP_EMIT   = 2'd2;

	typedef enum logic [1:0] {
		G_NONE,
		G_IN_VALID,
		G_OUT_FREE
	} guard_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_PH_GE_W,
		C_LAST
	} cond_t;

	typedef enum logic [1:0] {
		PH_HOLD,
		PH_LOAD,
		PH_SUB,
		PH_INC
	} ph_op_t;

	typedef struct packed {
		guard_t guard;
		logic   take;
		ph_op_t ph_op;
		logic   emit;
		cond_t  cond;
		pc_t    tgt_t;
		pc_t    tgt_f;
	} ucode_t;

	// actions of the current step, already gated by its guard
	typedef struct packed {
		logic   take;
		ph_op_t ph_op;
		logic   emit;
	} ctrl_t;

	typedef struct packed {
		logic out_free;
		logic ph_ge_w;
		logic last;
	} stat_t;

	// control store: fetch a byte, fold the phase under the width, emit cells
	function automatic ucode_t ter_ucode(input pc_t pc);
		ucode_t w;
		case (pc)
			STEP_REDUCE: begin
				w = '{guard: G_NONE, take: 1'b0, ph_op: PH_SUB, emit: 1'b0,
					cond: C_PH_GE_W, tgt_t: STEP_REDUCE, tgt_f: STEP_EMIT};
			end
			STEP_EMIT: begin
				w = '{guard: G_OUT_FREE, take: 1'b0, ph_op: PH_INC, emit: 1'b1,
					cond: C_LAST, tgt_t: STEP_FETCH, tgt_f: STEP_EMIT};
			end
			default: begin
				w = '{guard: G_IN_VALID, take: 1'b1, ph_op: PH_LOAD, emit: 1'b0,
					cond: C_ALWAYS, tgt_t: STEP_REDUCE, tgt_f: STEP_REDUCE};
			end
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/ter_channels.sv
// Valid/ready channel interfaces for source bytes and rendered cells.
// Depends on ter_pkg for field widths.

interface ter_in_if;
	logic                        valid;
	logic                        ready;
	logic [ter_pkg::CHAR_W-1:0]  in_char;
	logic                        first_of_row;

	modport source(output valid, output in_char, output first_of_row, input ready);
	modport sink(input valid, input in_char, input first_of_row, output ready);
endinterface

interface ter_out_if;
	logic                        valid;
	logic                        ready;
	logic [ter_pkg::CHAR_W-1:0]  out_char;
	logic [ter_pkg::HL_W-1:0]    hl_class;
	logic                        last_cell;

	modport source(output valid, output out_char, output hl_class, output last_cell,
		input ready);
	modport sink(input valid, input out_char, input hl_class, input last_cell,
		output ready);
endinterface

### hw/rtl/ter_sequencer.sv
// Step counter and control-store lookup: guards, actions and conditional jumps.
// Depends on ter_pkg for the control word and the program.

module ter_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ter_pkg::stat_t stat,
	output logic           in_ready,
	output ter_pkg::ctrl_t ctrl
);

	ter_pkg::pc_t   pc_q;
	ter_pkg::pc_t   pc_next;
	ter_pkg::ucode_t word;
	logic           fire;
	logic           cond_ok;

	assign word     = ter_pkg::ter_ucode(pc_q);
	assign in_ready = word.take;

	always_comb begin
		case (word.guard)
			ter_pkg::G_IN_VALID: fire = in_valid;
			ter_pkg::G_OUT_FREE: fire = stat.out_free;
			default:             fire = 1'b1;
		endcase
	end

	always_comb begin
		case (word.cond)
			ter_pkg::C_PH_GE_W: cond_ok = stat.ph_ge_w;
			ter_pkg::C_LAST:    cond_ok = stat.last;
			default:            cond_ok = 1'b1;
		endcase
	end

	always_comb begin
		if (!fire) begin
			pc_next = pc_q;
		end else if (cond_ok) begin
			pc_next = word.tgt_t;
		end else begin
			pc_next = word.tgt_f;
		end
	end

	always_comb begin
		ctrl.take  = fire & word.take;
		ctrl.emit  = fire & word.emit;
		ctrl.ph_op = fire ? word.ph_op : ter_pkg::PH_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ter_pkg::STEP_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

### hw/rtl/ter_datapath.sv
// Byte holding register, column phase unit, cell selection and output register.
// Depends on ter_pkg for widths, characters and control types.

module ter_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ter_pkg::ctrl_t              ctrl,
	output ter_pkg::stat_t              stat,
	input  logic [ter_pkg::CHAR_W-1:0]  in_char,
	input  logic                        first_of_row,
	input  logic [ter_pkg::IW_W-1:0]    width,
	input  logic                        tabs_mode,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [ter_pkg::CHAR_W-1:0]  out_char,
	output logic [ter_pkg::HL_W-1:0]    hl_class,
	output logic                        last_cell
);

	logic [ter_pkg::CHAR_W-1:0] char_q;
	logic [ter_pkg::PH_W-1:0]   phase_q;
	logic                       first_cell_q;
	logic                       out_valid_q;
	logic [ter_pkg::CHAR_W-1:0] out_char_q;
	logic [ter_pkg::HL_W-1:0]   hl_class_q;
	logic                       last_cell_q;

	logic [ter_pkg::IW_W-1:0]   phase_inc;
	logic                       wrap;
	logic                       is_tab;
	logic                       printable;
	logic [ter_pkg::CHAR_W-1:0] cell_char;
	logic [ter_pkg::HL_W-1:0]   cell_hl;

	assign phase_inc = {1'b0, phase_q} + ter_pkg::IW_W'(1);
	assign wrap      = (phase_inc == width);
	assign is_tab    = (char_q == ter_pkg::CH_TAB);
	assign printable = (char_q >= ter_pkg::CH_SPACE) && (char_q <= ter_pkg::CH_TILDE);

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.ph_ge_w  = ({1'b0, phase_q} >= width);
	assign stat.last     = !is_tab || wrap;

	always_comb begin
		if (is_tab) begin
			if (tabs_mode) begin
				cell_char = ter_pkg::CH_SPACE;
				cell_hl   = ter_pkg::HL_NORM;
			end else begin
				cell_char = first_cell_q ? ter_pkg::CH_MARK : ter_pkg::CH_SPACE;
				cell_hl   = ter_pkg::HL_TABFILL;
			end
		end else if (printable) begin
			cell_char = char_q;
			cell_hl   = ter_pkg::HL_NORM;
		end else begin
			cell_char = ter_pkg::CH_SUBST;
			cell_hl   = ter_pkg::HL_SUBST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			first_cell_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (ctrl.ph_op)
				ter_pkg::PH_LOAD: if (first_of_row) phase_q <= '0;
				ter_pkg::PH_SUB:  if (stat.ph_ge_w) begin
					phase_q <= ter_pkg::PH_W'({1'b0, phase_q} - width);
				end
				ter_pkg::PH_INC:  phase_q <= wrap ? '0 : ter_pkg::PH_W'(phase_inc);
				default:          phase_q <= phase_q;
			endcase
			if (ctrl.take) begin
				first_cell_q <= 1'b1;
			end else if (ctrl.emit) begin
				first_cell_q <= 1'b0;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			char_q <= in_char;
		end
		if (ctrl.emit) begin
			out_char_q  <= cell_char;
			hl_class_q  <= cell_hl;
			last_cell_q <= stat.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign hl_class  = hl_class_q;
	assign last_cell = last_cell_q;

endmodule

### hw/rtl/tab_expand_render_unit.sv
// Top level of the tab expansion renderer: configuration registers, sequencer and datapath.
// Depends on ter_pkg, ter_channels, ter_sequencer and ter_datapath.

// Each source byte taken on in_ch becomes one or more display cells on out_ch, one cell
// per transfer, the final cell of a byte flagged by last_cell. A small three-step program
// runs one step a cycle unless a step waits on its guard: fetch the byte, fold the column
// phase under the tab width, then emit cells. An ordinary byte yields one cell and a tab
// one cell per column that it fills; the fold step repeats once for each subtraction needed
// when the indent width has been lowered below the held phase in the middle of a row. The
// emit step stalls while the output register is full and not being taken, and the next byte
// is accepted while the last cell of the previous one still waits on out_ch. Indent width
// 0 behaves as 1 and values above 16 behave as 16. Write configuration only while idle.

module tab_expand_render_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	ter_in_if.sink                            in_ch,
	ter_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [ter_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ter_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [ter_pkg::IW_W-1:0] indent_q;
	logic                     tabs_mode_q;
	logic [ter_pkg::IW_W-1:0] width;
	ter_pkg::ctrl_t           ctrl;
	ter_pkg::stat_t           stat;

	// cfg registers; user must make writes land only while the block is idle (unchecked)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indent_q    <= ter_pkg::INDENT_RST;
			tabs_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				ter_pkg::REG_INDENT:    indent_q    <= cfg_wdata;
				ter_pkg::REG_TABS_MODE: tabs_mode_q <= cfg_wdata[0];
				default:                indent_q    <= indent_q;
			endcase
		end
	end

	// effective tab stop spacing: clamp into 1..MAX_INDENT
	always_comb begin
		if (indent_q == '0) begin
			width = ter_pkg::IW_W'(1);
		end else if (indent_q > ter_pkg::INDENT_MAX) begin
			width = ter_pkg::INDENT_MAX;
		end else begin
			width = indent_q;
		end
	end

	ter_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.stat     (stat),
		.in_ready (in_ch.ready),
		.ctrl     (ctrl)
	);

	ter_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.in_char      (in_ch.in_char),
		.first_of_row (in_ch.first_of_row),
		.width        (width),
		.tabs_mode    (tabs_mode_q),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.out_char     (out_ch.out_char),
		.hl_class     (out_ch.hl_class),
		.last_cell    (out_ch.last_cell)
	);

endmodule

### hw/rtl/ter_checker.sv
// Port-level checks for tab_expand_render_unit, attached with a bind.
// Depends on ter_pkg for characters and highlight classes.

module ter_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ter_pkg::CHAR_W-1:0]  out_char,
	input logic [ter_pkg::HL_W-1:0]    hl_class,
	input logic                        last_cell
);

	// a stalled cell must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(hl_class)
			&& $stable(last_cell))
		else $error("rendered cell changed while stalled");

	// one byte at a time: no transfer in the cycle after a transfer
	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after a transfer");

	// substitute cells are single and always '?'
	a_subst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hl_class == ter_pkg::HL_SUBST |->
			last_cell && out_char == ter_pkg::CH_SUBST)
		else $error("bad substitute cell");

	// tab fill cells are marker or space
	a_tab_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hl_class == ter_pkg::HL_TABFILL |->
			out_char == ter_pkg::CH_MARK || out_char == ter_pkg::CH_SPACE)
		else $error("bad tab fill cell");

endmodule

bind tab_expand_render_unit ter_checker u_ter_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.hl_class  (out_ch.hl_class),
	.last_cell (out_ch.last_cell)
);
